// ----- rtl/frm_pkg.sv -----
package frm_pkg;

   // Sign and zero-length status of one axis component, carried along the lanes
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   // Center is the corner sum times 0.25, rounded half away from zero
   localparam int unsigned CenterShift = 2;
   localparam int unsigned CenterRound = 2;

endpackage

// ----- rtl/frm_if.sv -----
interface frm_req_if #(parameter int CW = 24) ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] corner0_x;
   logic signed [CW-1:0] corner0_y;
   logic signed [CW-1:0] corner0_z;
   logic signed [CW-1:0] corner1_x;
   logic signed [CW-1:0] corner1_y;
   logic signed [CW-1:0] corner1_z;
   logic signed [CW-1:0] corner2_x;
   logic signed [CW-1:0] corner2_y;
   logic signed [CW-1:0] corner2_z;
   logic signed [CW-1:0] corner3_x;
   logic signed [CW-1:0] corner3_y;
   logic signed [CW-1:0] corner3_z;

   modport source (
      output valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
             corner2_x, corner2_y, corner2_z, corner3_x, corner3_y, corner3_z,
      input  ready
   );
   modport sink (
      input  valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
             corner2_x, corner2_y, corner2_z, corner3_x, corner3_y, corner3_z,
      output ready
   );
endinterface

interface frm_rsp_if #(parameter int CW = 24, parameter int AXW = 16) ();
   logic                  valid;
   logic                  ready;
   logic signed [AXW-1:0] axis0_x;
   logic signed [AXW-1:0] axis0_y;
   logic signed [AXW-1:0] axis0_z;
   logic signed [AXW-1:0] axis1_x;
   logic signed [AXW-1:0] axis1_y;
   logic signed [AXW-1:0] axis1_z;
   logic signed [AXW-1:0] axis2_x;
   logic signed [AXW-1:0] axis2_y;
   logic signed [AXW-1:0] axis2_z;
   logic signed [CW-1:0]  center_x;
   logic signed [CW-1:0]  center_y;
   logic signed [CW-1:0]  center_z;

   modport source (
      output valid, axis0_x, axis0_y, axis0_z, axis1_x, axis1_y, axis1_z,
             axis2_x, axis2_y, axis2_z, center_x, center_y, center_z,
      input  ready
   );
   modport sink (
      input  valid, axis0_x, axis0_y, axis0_z, axis1_x, axis1_y, axis1_z,
             axis2_x, axis2_y, axis2_z, center_x, center_y, center_z,
      output ready
   );
endinterface

// ----- rtl/frm_front.sv -----
module frm_front #(
   parameter int CW = 24
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [CW-1:0]   corner [4][3],
   output logic signed [CW+1:0]   axis0 [3],
   output logic signed [CW+1:0]   axis2 [3],
   output logic signed [2*CW+3:0] axis1 [3],
   output logic signed [CW-1:0]   center [3]
);
   localparam int AW = CW + 2;
   localparam int PW = 2 * AW;

   logic signed [AW-1:0] d1     [3];
   logic signed [AW-1:0] d2     [3];
   logic signed [AW-1:0] a0_ff  [3];
   logic signed [AW-1:0] a2_ff  [3];
   logic signed [AW-1:0] a0d_ff [3];
   logic signed [AW-1:0] a2d_ff [3];
   logic signed [AW-1:0] a0o_ff [3];
   logic signed [AW-1:0] a2o_ff [3];
   logic signed [AW-1:0] sum_ff [3];
   logic [AW-1:0]        smag   [3];
   logic [AW-1:0]        srnd   [3];
   logic [CW-1:0]        cmag   [3];
   logic signed [CW-1:0] ctr_ff [3];
   logic signed [CW-1:0] ctro_ff[3];
   logic signed [PW-1:0] pa_in  [3];
   logic signed [PW-1:0] pb_in  [3];
   logic signed [PW-1:0] pa_ff  [3];
   logic signed [PW-1:0] pb_ff  [3];
   logic signed [PW-1:0] x_ff   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1[i]   = AW'(corner[2][i]) - AW'(corner[0][i]);
         d2[i]   = AW'(corner[3][i]) - AW'(corner[1][i]);
         smag[i] = sum_ff[i][AW-1] ? AW'(-sum_ff[i]) : AW'(sum_ff[i]);
         srnd[i] = smag[i] + AW'(frm_pkg::CenterRound);
         cmag[i] = CW'(srnd[i] >> frm_pkg::CenterShift);
      end
   end

   // axis1 = axis2 x axis0, component i from the two other components
   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      assign pa_in[i] = PW'(a2_ff[J]) * PW'(a0_ff[K]);
      assign pb_in[i] = PW'(a2_ff[K]) * PW'(a0_ff[J]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            a0_ff[i]   <= d1[i] + d2[i];
            a2_ff[i]   <= d1[i] - d2[i];
            sum_ff[i]  <= (AW'(corner[0][i]) + AW'(corner[1][i]))
                        + (AW'(corner[2][i]) + AW'(corner[3][i]));
            pa_ff[i]   <= pa_in[i];
            pb_ff[i]   <= pb_in[i];
            a0d_ff[i]  <= a0_ff[i];
            a2d_ff[i]  <= a2_ff[i];
            ctr_ff[i]  <= sum_ff[i][AW-1] ? -cmag[i] : cmag[i];
            x_ff[i]    <= pa_ff[i] - pb_ff[i];
            a0o_ff[i]  <= a0d_ff[i];
            a2o_ff[i]  <= a2d_ff[i];
            ctro_ff[i] <= ctr_ff[i];
         end
      end
   end

   assign axis0  = a0o_ff;
   assign axis2  = a2o_ff;
   assign axis1  = x_ff;
   assign center = ctro_ff;

endmodule

// ----- rtl/frm_lane.sv -----
module frm_lane #(
   parameter int SW = 106,
   parameter int QW = 104,
   parameter int F  = 14
) (
   input  logic               clock,
   input  logic               en,
   input  logic [QW-1:0]      sq,
   input  frm_pkg::sign_type  sgn,
   input  logic [SW-1:0]      s_pipe [F+2],
   output logic [F:0]         q,
   output frm_pkg::sign_type  q_sgn
);
   localparam int RW    = SW + 2*F + 6;
   localparam int STEPS = F + 1;

   // r: target minus (2q-1)^2 * S, p: S * (2q-1)
   logic signed [RW-1:0] r_ff  [STEPS+1];
   logic signed [RW-1:0] p_ff  [STEPS+1];
   logic [F:0]           q_ff  [STEPS+1];
   frm_pkg::sign_type    sg_ff [STEPS+1];
   logic signed [RW-1:0] rn    [STEPS];
   logic [STEPS-1:0]     acc;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]  <= (RW'(sq) << (2*F + 2)) - RW'(s_pipe[0]);
         p_ff[0]  <= -RW'(s_pipe[0]);
         q_ff[0]  <= '0;
         sg_ff[0] <= sgn;
      end
   end

   // one result bit per stage, most significant first
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int B = F - k;
      always_comb begin
         rn[k]  = r_ff[k] - (p_ff[k] <<< (B + 2)) - (RW'(s_pipe[k+1]) << (2*B + 2));
         acc[k] = !rn[k][RW-1] && !q_ff[k][F];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]  <= acc[k] ? rn[k] : r_ff[k];
            p_ff[k+1]  <= acc[k] ? p_ff[k] + (RW'(s_pipe[k+1]) << (B + 1)) : p_ff[k];
            q_ff[k+1]  <= q_ff[k] | ((F+1)'(acc[k]) << B);
            sg_ff[k+1] <= sg_ff[k];
         end
      end
   end

   assign q     = q_ff[STEPS];
   assign q_sgn = sg_ff[STEPS];

endmodule

// ----- rtl/frm_axis.sv -----
module frm_axis #(
   parameter int VW = 26,
   parameter int F  = 14
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [VW-1:0] vec [3],
   output logic [F:0]          unit_mag [3],
   output frm_pkg::sign_type   unit_sgn [3]
);
   localparam int HW    = (VW + 1) / 2;
   localparam int UW    = VW - HW;
   localparam int QW    = 2 * VW;
   localparam int SW    = QW + 2;
   localparam int STEPS = F + 1;

   logic                vzero;
   logic [VW-1:0]       mag_ff  [3];
   frm_pkg::sign_type   sg_m_ff [3];
   frm_pkg::sign_type   sg_p_ff [3];
   frm_pkg::sign_type   sg_q_ff [3];
   frm_pkg::sign_type   sg_s_ff [3];
   logic [2*UW-1:0]     hh_ff   [3];
   logic [VW-1:0]       hl_ff   [3];
   logic [2*HW-1:0]     ll_ff   [3];
   logic [QW-1:0]       sq_ff   [3];
   logic [QW-1:0]       sq_s_ff [3];
   logic [SW-1:0]       s_ff    [STEPS+1];

   assign vzero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
            sg_m_ff[i] <= '{neg: vec[i][VW-1], zero: vzero};
            // square split into high and low halves
            hh_ff[i]   <= (2*UW)'(mag_ff[i][VW-1:HW]) * (2*UW)'(mag_ff[i][VW-1:HW]);
            hl_ff[i]   <= VW'(mag_ff[i][VW-1:HW]) * VW'(mag_ff[i][HW-1:0]);
            ll_ff[i]   <= (2*HW)'(mag_ff[i][HW-1:0]) * (2*HW)'(mag_ff[i][HW-1:0]);
            sg_p_ff[i] <= sg_m_ff[i];
            sq_ff[i]   <= (QW'(hh_ff[i]) << (2*HW)) + (QW'(hl_ff[i]) << (HW + 1))
                        + QW'(ll_ff[i]);
            sg_q_ff[i] <= sg_p_ff[i];
            sq_s_ff[i] <= sq_ff[i];
            sg_s_ff[i] <= sg_q_ff[i];
         end
         s_ff[0] <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
         for (int k = 0; k < STEPS; k++) begin
            s_ff[k+1] <= s_ff[k];
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      frm_lane #(
         .SW (SW),
         .QW (QW),
         .F  (F)
      ) u_lane (
         .clock  (clock),
         .en     (en),
         .sq     (sq_s_ff[i]),
         .sgn    (sg_s_ff[i]),
         .s_pipe (s_ff),
         .q      (unit_mag[i]),
         .q_sgn  (unit_sgn[i])
      );
   end

endmodule

// ----- rtl/frame_from_four_corners.sv -----
// Channel | Dir | Beat contents
// req_bus | in  | four corners c0..c3, x/y/z each, signed, 10 fraction bits
// rsp_bus | out | axis0/1/2 x/y/z unit vectors in Q1.(AXIS_WIDTH-2), center x/y/z
//
// One beat accepted per cycle while no rsp beat is held.
// Pipeline depth is set by the unit-length search: one pipeline stage per result bit
// in each of the nine component lanes, after three front and four square stages.
// Reset clears only the valid pipeline and the output valid.
// A held rsp beat freezes the whole pipeline and drops req_bus.ready.
module frame_from_four_corners #(
   parameter int COORD_WIDTH = 24,
   parameter int AXIS_WIDTH  = 16
) (
   input  logic       clock,
   input  logic       reset,
   frm_req_if.sink    req_bus,
   frm_rsp_if.source  rsp_bus
);
   localparam int F   = AXIS_WIDTH - 2;
   localparam int AW  = COORD_WIDTH + 2;
   localparam int NST = F + 9;
   localparam int CD  = F + 6;
   localparam logic signed [AXIS_WIDTH-1:0] AxOne = AXIS_WIDTH'(1) << F;

   logic                          en;
   logic [NST-1:0]                vld_ff;
   logic                          rsp_valid_ff;
   logic signed [COORD_WIDTH-1:0] corner  [4][3];
   logic signed [AW-1:0]          a0_v    [3];
   logic signed [AW-1:0]          a2_v    [3];
   logic signed [2*AW-1:0]        a1_v    [3];
   logic signed [COORD_WIDTH-1:0] ctr_v   [3];
   logic signed [COORD_WIDTH-1:0] ctr_ff  [CD];
   logic signed [COORD_WIDTH-1:0] cto_ff  [3];
   logic [F:0]                    u_mag   [3][3];
   frm_pkg::sign_type             u_sgn   [3][3];
   logic signed [AXIS_WIDTH-1:0]  ax_in   [3][3];
   logic signed [AXIS_WIDTH-1:0]  ax_ff   [3][3];
   logic                          rng_ok;

   // advance whenever the output register is empty or being drained
   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   assign corner[0][0] = req_bus.corner0_x;
   assign corner[0][1] = req_bus.corner0_y;
   assign corner[0][2] = req_bus.corner0_z;
   assign corner[1][0] = req_bus.corner1_x;
   assign corner[1][1] = req_bus.corner1_y;
   assign corner[1][2] = req_bus.corner1_z;
   assign corner[2][0] = req_bus.corner2_x;
   assign corner[2][1] = req_bus.corner2_y;
   assign corner[2][2] = req_bus.corner2_z;
   assign corner[3][0] = req_bus.corner3_x;
   assign corner[3][1] = req_bus.corner3_y;
   assign corner[3][2] = req_bus.corner3_z;

   frm_front #(
      .CW (COORD_WIDTH)
   ) u_front (
      .clock  (clock),
      .en     (en),
      .corner (corner),
      .axis0  (a0_v),
      .axis2  (a2_v),
      .axis1  (a1_v),
      .center (ctr_v)
   );

   frm_axis #(.VW(AW), .F(F)) u_axis0 (
      .clock (clock), .en (en), .vec (a0_v), .unit_mag (u_mag[0]), .unit_sgn (u_sgn[0])
   );

   frm_axis #(.VW(2*AW), .F(F)) u_axis1 (
      .clock (clock), .en (en), .vec (a1_v), .unit_mag (u_mag[1]), .unit_sgn (u_sgn[1])
   );

   frm_axis #(.VW(AW), .F(F)) u_axis2 (
      .clock (clock), .en (en), .vec (a2_v), .unit_mag (u_mag[2]), .unit_sgn (u_sgn[2])
   );

   // merge lane results: apply sign, force zero-length axes to zero
   always_comb begin
      rng_ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < 3; i++) begin
            if (u_sgn[a][i].zero) begin
               ax_in[a][i] = '0;
            end else if (u_sgn[a][i].neg) begin
               ax_in[a][i] = -AXIS_WIDTH'(u_mag[a][i]);
            end else begin
               ax_in[a][i] = AXIS_WIDTH'(u_mag[a][i]);
            end
            if (ax_ff[a][i] > AxOne || ax_ff[a][i] < -AxOne) begin
               rng_ok = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[NST-2:0], req_bus.valid};
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctr_ff[0] <= ctr_v[0];
         for (int k = 1; k < CD; k++) begin
            ctr_ff[k] <= ctr_ff[k-1];
         end
         ax_ff <= ax_in;
         cto_ff[0] <= ctr_ff[CD-1];
      end
   end

   // y and z centers ride in their own short delay lines
   logic signed [COORD_WIDTH-1:0] cy_ff [CD];
   logic signed [COORD_WIDTH-1:0] cz_ff [CD];

   always_ff @(posedge clock) begin
      if (en) begin
         cy_ff[0] <= ctr_v[1];
         cz_ff[0] <= ctr_v[2];
         for (int k = 1; k < CD; k++) begin
            cy_ff[k] <= cy_ff[k-1];
            cz_ff[k] <= cz_ff[k-1];
         end
         cto_ff[1] <= cy_ff[CD-1];
         cto_ff[2] <= cz_ff[CD-1];
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.axis0_x  = ax_ff[0][0];
   assign rsp_bus.axis0_y  = ax_ff[0][1];
   assign rsp_bus.axis0_z  = ax_ff[0][2];
   assign rsp_bus.axis1_x  = ax_ff[1][0];
   assign rsp_bus.axis1_y  = ax_ff[1][1];
   assign rsp_bus.axis1_z  = ax_ff[1][2];
   assign rsp_bus.axis2_x  = ax_ff[2][0];
   assign rsp_bus.axis2_y  = ax_ff[2][1];
   assign rsp_bus.axis2_z  = ax_ff[2][2];
   assign rsp_bus.center_x = cto_ff[0];
   assign rsp_bus.center_y = cto_ff[1];
   assign rsp_bus.center_z = cto_ff[2];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> vld_ff[0])
      else $error("accepted beat did not enter the pipeline");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("req accepted while output beat is held");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rng_ok)
      else $error("axis component exceeds unit magnitude");

endmodule
